/* sv/polytope_hit_and_run_step_top_defines.svh */
// Assertion macros shared by the checker of the hit-and-run step block
`ifndef POLYTOPE_HIT_AND_RUN_STEP_TOP_DEFINES_SVH
`define POLYTOPE_HIT_AND_RUN_STEP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PHR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PHR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/phr_pkg.sv */
// Types, codes and saturation helper for the hit-and-run step block
`timescale 1ns / 1ps
package phr_pkg;

  // Request opcodes
  localparam logic [2:0] OP_WR_COEF  = 3'd0;
  localparam logic [2:0] OP_WR_BOUND = 3'd1;
  localparam logic [2:0] OP_WR_POINT = 3'd2;
  localparam logic [2:0] OP_DIR      = 3'd3;
  localparam logic [2:0] OP_MEMBER   = 3'd4;

  // Result error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNBOUNDED = 2'd1;
  localparam logic [1:0] ERR_EMPTY     = 2'd2;

  // Result kinds
  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_MEMBER = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_FACE_COUNT = 2'd0;
  localparam logic [1:0] CFG_DIM        = 2'd1;

  // Quotient bits produced by the serial divider
  localparam int DIV_STEPS = 48;

  typedef struct packed {
    logic [2:0]         op;
    logic [4:0]         face_index;
    logic [2:0]         coord_index;
    logic signed [31:0] value;
    logic [15:0]        theta_fraction;
    logic               final_step;
  } phr_req_t;

  typedef struct packed {
    logic               kind;
    logic [2:0]         out_coord;
    logic signed [31:0] coord_value;
    logic               in_set;
    logic [1:0]         error;
    logic               last_result;
  } phr_res_t;

  // Clamp a signed wide value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sh0_0000_0000_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -72'sh0_0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/polytope_hit_and_run_step_top.sv */
// Top level of the hit-and-run step block: memories, sequencer and datapath
// Writes of A, b and x leave busy low; writing the last component of d starts a step.
// Step: one read-multiply-add per coordinate, serial divider per face with a nonzero rate;
// the last strobe comes in the same cycle that busy falls, and a next request can be taken then.
// Reset (synchronous, rst_n low) sets face_count and dim to 1 and idles the sequencer.
`timescale 1ns / 1ps
module polytope_hit_and_run_step_top #(
  parameter int MAX_FACES = 32,
  parameter int MAX_DIMS  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  phr_pkg::phr_req_t in_req,
  output logic              out_strobe,
  output phr_pkg::phr_res_t out_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import phr_pkg::*;

  localparam int FIW       = $clog2(MAX_FACES);
  localparam int DIW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int MAT_DEPTH = MAX_FACES * (1 << DIW);
  localparam int PW        = 64 + DIW + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DOT_RD, ST_DOT_MUL, ST_DOT_ACC, ST_FACE, ST_DIV_GO, ST_DIV_WAIT,
    ST_TH_DIFF, ST_TH_MUL, ST_TH_ADD, ST_MV_RD, ST_MV_MUL, ST_MV_WR
  } state_t;

  // Memories
  logic signed [31:0] mat_mem   [MAT_DEPTH];
  logic signed [31:0] bound_mem [MAX_FACES];
  logic signed [31:0] point_mem [MAX_DIMS];
  logic signed [31:0] dir_mem   [MAX_DIMS];

  logic signed [31:0] a_rd, b_rd, x_rd, d_rd;

  state_t              state_r;
  logic [FIW-1:0]      i_r;
  logic [DIW-1:0]      j_r;
  logic [5:0]          face_count_r;
  logic [3:0]          dim_r;
  logic                member_r, final_r, in_set_r;
  logic [15:0]         frac_r;
  logic signed [63:0]  pax_r, pad_r, mv_prod_r;
  logic signed [PW-1:0] acc_x_r, acc_d_r;
  logic signed [31:0]  rate_r, slack_r, tmin_r, tmax_r, theta_r;
  logic                have_lo_r, have_hi_r;
  logic signed [32:0]  diff_r;
  logic [48:0]         tprod_r;
  logic                out_strobe_r;
  phr_res_t            out_res_r;

  logic [FIW:0]        nf, nf_m1;
  logic [DIW:0]        nd, nd_m1;
  logic                acc_in, face_ok, coord_ok;
  logic                last_face, last_coord, face_done;
  logic signed [31:0]  slack_c, rate_c, new_x;
  logic signed [PW-1:0] b_scaled;
  logic                div_start, div_done;
  logic signed [31:0]  div_quot;
  logic                mat_we, bound_we, point_we, dir_we;
  logic [DIW-1:0]      point_waddr;
  logic signed [31:0]  point_wdata;
  logic [FIW+DIW-1:0]  mat_waddr;

  // Clamp the configured counts to the supported range
  always_comb begin
    if (face_count_r == 6'd0) begin
      nf = (FIW+1)'(1);
    end else if (32'(face_count_r) > MAX_FACES) begin
      nf = (FIW+1)'(MAX_FACES);
    end else begin
      nf = (FIW+1)'(face_count_r);
    end
    if (dim_r == 4'd0) begin
      nd = (DIW+1)'(1);
    end else if (32'(dim_r) > MAX_DIMS) begin
      nd = (DIW+1)'(MAX_DIMS);
    end else begin
      nd = (DIW+1)'(dim_r);
    end
    nf_m1 = nf - 1'b1;
    nd_m1 = nd - 1'b1;
  end

  // Take configuration only while no request is in flight
  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = !busy;
  assign acc_in     = start && !busy;
  assign face_ok    = 32'(in_req.face_index) < MAX_FACES;
  assign coord_ok   = 32'(in_req.coord_index) < MAX_DIMS;
  assign last_face  = ({1'b0, i_r} == nf_m1);
  assign last_coord = ({1'b0, j_r} == nd_m1);

  // Write ports: requests while idle, point updates during a step
  assign mat_we      = acc_in && (in_req.op == OP_WR_COEF) && face_ok && coord_ok;
  assign bound_we    = acc_in && (in_req.op == OP_WR_BOUND) && face_ok;
  assign dir_we      = acc_in && (in_req.op == OP_DIR) && coord_ok;
  assign point_we    = (acc_in && (in_req.op == OP_WR_POINT) && coord_ok)
                       || (state_r == ST_MV_WR);
  assign point_waddr = busy ? j_r : DIW'(in_req.coord_index);
  assign point_wdata = busy ? new_x : in_req.value;
  assign mat_waddr   = {FIW'(in_req.face_index), DIW'(in_req.coord_index)};

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= in_req.value;
    end
    a_rd <= mat_mem[{i_r, j_r}];
  end

  always_ff @(posedge clk) begin
    if (bound_we) begin
      bound_mem[FIW'(in_req.face_index)] <= in_req.value;
    end
    b_rd <= bound_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (point_we) begin
      point_mem[point_waddr] <= point_wdata;
    end
    x_rd <= point_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[DIW'(in_req.coord_index)] <= in_req.value;
    end
    d_rd <= dir_mem[j_r];
  end

  // Per-face slack, rate and membership bound
  assign slack_c   = sat32(72'(b_rd) - 72'(acc_x_r >>> 16));
  assign rate_c    = sat32(72'(acc_d_r >>> 16));
  assign b_scaled  = PW'(b_rd) <<< 16;
  assign face_done = ((state_r == ST_FACE) && (member_r || (rate_c == 32'sd0)))
                     || ((state_r == ST_DIV_WAIT) && div_done);
  assign div_start = (state_r == ST_DIV_GO);

  // Move one coordinate along the direction
  assign new_x = sat32(72'(x_rd) + 72'(mv_prod_r >>> 16));

  phr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .slack (slack_r),
    .rate  (rate_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      face_count_r <= 6'd1;
      dim_r        <= 4'd1;
      out_strobe_r <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
    end else begin
      // Take configuration writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FACE_COUNT) begin
          face_count_r <= cfg_data[5:0];
        end else if (cfg_index == CFG_DIM) begin
          dim_r <= cfg_data[3:0];
        end
      end

      case (state_r)
        ST_IDLE: begin
          out_strobe_r <= 1'b0;
          i_r       <= '0;
          j_r       <= '0;
          acc_x_r   <= '0;
          acc_d_r   <= '0;
          have_lo_r <= 1'b0;
          have_hi_r <= 1'b0;
          in_set_r  <= 1'b1;
          frac_r    <= in_req.theta_fraction;
          final_r   <= in_req.final_step;
          if (acc_in && (in_req.op == OP_MEMBER)) begin
            member_r <= 1'b1;
            state_r  <= ST_DOT_RD;
          end else if (acc_in && (in_req.op == OP_DIR)
                       && ((32'(in_req.coord_index) + 1) == 32'(nd))) begin
            member_r <= 1'b0;
            state_r  <= ST_DOT_RD;
          end
        end
        ST_DOT_RD: begin
          out_strobe_r <= 1'b0;
          state_r      <= ST_DOT_MUL;
        end
        ST_DOT_MUL: begin
          out_strobe_r <= 1'b0;
          pax_r   <= a_rd * x_rd;
          pad_r   <= a_rd * d_rd;
          state_r <= ST_DOT_ACC;
        end
        ST_DOT_ACC: begin
          out_strobe_r <= 1'b0;
          acc_x_r <= acc_x_r + PW'(pax_r);
          acc_d_r <= acc_d_r + PW'(pad_r);
          if (last_coord) begin
            state_r <= ST_FACE;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_DOT_RD;
          end
        end
        ST_FACE: begin
          out_strobe_r <= face_done && last_face && member_r;
          slack_r <= slack_c;
          rate_r  <= rate_c;
          if (member_r) begin
            in_set_r <= in_set_r && (acc_x_r <= b_scaled);
          end else if (rate_c != 32'sd0) begin
            state_r <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          out_strobe_r <= 1'b0;
          state_r      <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          out_strobe_r <= 1'b0;
          if (div_done) begin
            if (rate_r[31]) begin
              if (!have_lo_r || (div_quot > tmin_r)) begin
                tmin_r <= div_quot;
              end
              have_lo_r <= 1'b1;
            end else begin
              if (!have_hi_r || (div_quot < tmax_r)) begin
                tmax_r <= div_quot;
              end
              have_hi_r <= 1'b1;
            end
          end
        end
        ST_TH_DIFF: begin
          // Report a chord with a missing limit, then one that is empty
          if (!have_lo_r || !have_hi_r) begin
            out_strobe_r <= 1'b1;
            out_res_r    <= '{kind: KIND_POINT, out_coord: 3'd0, coord_value: 32'sd0,
                              in_set: 1'b0, error: ERR_UNBOUNDED, last_result: 1'b1};
            state_r      <= ST_IDLE;
          end else if (tmax_r < tmin_r) begin
            out_strobe_r <= 1'b1;
            out_res_r    <= '{kind: KIND_POINT, out_coord: 3'd0, coord_value: 32'sd0,
                              in_set: 1'b0, error: ERR_EMPTY, last_result: 1'b1};
            state_r      <= ST_IDLE;
          end else begin
            out_strobe_r <= 1'b0;
            diff_r       <= 33'(tmax_r) - 33'(tmin_r);
            state_r      <= ST_TH_MUL;
          end
        end
        ST_TH_MUL: begin
          out_strobe_r <= 1'b0;
          tprod_r <= diff_r[32:0] * {33'd0, frac_r};
          state_r <= ST_TH_ADD;
        end
        ST_TH_ADD: begin
          out_strobe_r <= 1'b0;
          theta_r <= 32'(34'(tmin_r) + 34'(signed'({1'b0, tprod_r[48:16]})));
          j_r     <= '0;
          state_r <= ST_MV_RD;
        end
        ST_MV_RD: begin
          out_strobe_r <= 1'b0;
          state_r      <= ST_MV_MUL;
        end
        ST_MV_MUL: begin
          out_strobe_r <= 1'b0;
          mv_prod_r <= theta_r * d_rd;
          state_r   <= ST_MV_WR;
        end
        ST_MV_WR: begin
          out_strobe_r <= final_r;
          if (final_r) begin
            out_res_r <= '{kind: KIND_POINT, out_coord: 3'(j_r), coord_value: new_x,
                           in_set: 1'b0, error: ERR_NONE, last_result: last_coord};
          end
          if (last_coord) begin
            state_r <= ST_IDLE;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_MV_RD;
          end
        end
        default: begin
          out_strobe_r <= 1'b0;
          state_r      <= ST_IDLE;
        end
      endcase

      // Advance to the next face or finish the sweep
      if (face_done) begin
        if (last_face) begin
          if (member_r) begin
            out_res_r <= '{kind: KIND_MEMBER, out_coord: 3'd0, coord_value: 32'sd0,
                           in_set: in_set_r && (acc_x_r <= b_scaled), error: ERR_NONE,
                           last_result: 1'b1};
            state_r   <= ST_IDLE;
          end else begin
            state_r <= ST_TH_DIFF;
          end
        end else begin
          i_r     <= i_r + 1'b1;
          j_r     <= '0;
          acc_x_r <= '0;
          acc_d_r <= '0;
          state_r <= ST_DOT_RD;
        end
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

/* sv/phr_divider.sv */
// Serial signed divider: saturated trunc(slack * 2^16 / rate), one bit a cycle
`timescale 1ns / 1ps
module phr_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] slack,
  input  logic signed [31:0] rate,
  output logic               done,
  output logic signed [31:0] quot
);
  import phr_pkg::*;

  localparam logic [5:0] LAST_STEP = 6'(DIV_STEPS - 1);

  logic        run_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [47:0] num_r;
  logic [47:0] qmag_r;
  logic [31:0] den_r;
  logic        neg_r;
  logic        done_r;
  logic signed [31:0] quot_r;

  logic [32:0] shifted;
  logic        ge;
  logic [31:0] rem_nxt;
  logic [47:0] qmag_nxt;
  logic [31:0] slack_mag;
  logic [31:0] rate_mag;
  logic signed [31:0] quot_nxt;

  // Magnitudes of the operands
  assign slack_mag = slack[31] ? 32'(-slack) : 32'(slack);
  assign rate_mag  = rate[31]  ? 32'(-rate)  : 32'(rate);

  // One restoring step
  always_comb begin
    shifted  = {rem_r, num_r[47]};
    ge       = shifted >= {1'b0, den_r};
    rem_nxt  = ge ? 32'(shifted - {1'b0, den_r}) : shifted[31:0];
    qmag_nxt = {qmag_r[46:0], ge};
  end

  // Apply sign and saturate the finished quotient
  always_comb begin
    if (neg_r) begin
      quot_nxt = (qmag_nxt > 48'h0000_8000_0000) ? 32'sh8000_0000 : 32'(-qmag_nxt[31:0]);
    end else begin
      quot_nxt = (qmag_nxt > 48'h0000_7fff_ffff) ? 32'sh7fff_ffff : 32'(qmag_nxt[31:0]);
    end
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      num_r  <= {slack_mag, 16'h0000};
      qmag_r <= '0;
      den_r  <= rate_mag;
      neg_r  <= slack[31] ^ rate[31];
    end else if (run_r) begin
      rem_r  <= rem_nxt;
      num_r  <= {num_r[46:0], 1'b0};
      qmag_r <= qmag_nxt;
      if (cnt_r == LAST_STEP) begin
        quot_r <= quot_nxt;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* sv/phr_checker.sv */
// Port-level checker for the hit-and-run step block and its bind
`timescale 1ns / 1ps
`include "polytope_hit_and_run_step_top_defines.svh"
module phr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input phr_pkg::phr_req_t in_req,
  input logic              out_strobe,
  input phr_pkg::phr_res_t out_res,
  input logic              cfg_valid,
  input logic              cfg_ready
);
  import phr_pkg::*;

  // Results only come out of a request at work
  `PHR_ASSERT_NOW(a_strobe_from_work, out_strobe, $past(busy), "result without active request")
  // The last result of a request closes the burst
  `PHR_ASSERT_NEXT(a_last_closes, out_strobe && out_res.last_result, !out_strobe, "result after last")
  // Membership answers carry no error and no coordinate
  `PHR_ASSERT_NOW(a_member_clean, out_strobe && (out_res.kind == KIND_MEMBER), (out_res.error == ERR_NONE) && (out_res.coord_value == 32'sd0), "dirty membership result")
  // Load requests complete in their own cycle
  `PHR_ASSERT_NEXT(a_load_quick, start && !busy && ((in_req.op == OP_WR_COEF) || (in_req.op == OP_WR_BOUND) || (in_req.op == OP_WR_POINT)), !busy && !out_strobe, "load request held the block")
  // Configuration lands only while idle
  `PHR_ASSERT_NOW(a_cfg_idle, cfg_valid && cfg_ready, !busy, "configuration taken while busy")

endmodule

bind polytope_hit_and_run_step_top phr_checker u_phr_checker (.*);

/* bench/polytope_hit_and_run_step_top_tb.sv */
// Self-checking testbench for the polytope hit-and-run step block
`timescale 1ns / 1ps
module polytope_hit_and_run_step_top_tb;
  import phr_pkg::*;

  localparam int NF = 32;
  localparam int ND = 8;
  // long enough for the longest step over all faces, plus margin
  localparam int SETTLE_CYCLES = 2800;
  localparam int ONE = 65536;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  phr_req_t in_req = '0;
  logic     out_strobe;
  phr_res_t out_res;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_FACE_COUNT;
  logic [7:0] cfg_data = '0;

  // shadow of the block state
  int coef [NF][ND];
  int bnd [NF];
  int pt [ND];
  int dir [ND];
  int faces_raw = 1;
  int dims_raw = 1;

  phr_res_t pending_results[$];
  int mismatches = 0;
  int burst_left = 0;
  bit bursty = 1'b1;

  polytope_hit_and_run_step_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int eff_faces();
    return (faces_raw < 1) ? 1 : (faces_raw > NF ? NF : faces_raw);
  endfunction

  function automatic int eff_dims();
    return (dims_raw < 1) ? 1 : (dims_raw > ND ? ND : dims_raw);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
    if (v > 80'sh7fff_ffff) return 32'sh7fff_ffff;
    if (v < -80'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // exact row dot product in Q32.32, wide enough for all 8 terms
  function automatic logic signed [79:0] row_dot(input int f, input bit use_dir);
    logic signed [79:0] acc;
    logic signed [79:0] a;
    logic signed [79:0] b;
    acc = '0;
    for (int j = 0; j < eff_dims(); j++) begin
      a = 80'(coef[f][j]);
      b = use_dir ? 80'(dir[j]) : 80'(pt[j]);
      acc = acc + a * b;
    end
    return acc;
  endfunction

  function automatic phr_res_t mk_res(logic kind, int crd, int val, logic ins,
                                      logic [1:0] err, logic last);
    phr_res_t r;
    r.kind = kind;
    r.out_coord = crd[2:0];
    r.coord_value = val;
    r.in_set = ins;
    r.error = err;
    r.last_result = last;
    return r;
  endfunction

  // chord limits, theta and the move of the point
  function automatic void chord_step(input logic [15:0] frac, input logic fin);
    logic signed [79:0] slack;
    logic signed [79:0] rate;
    logic signed [79:0] q;
    logic signed [79:0] w;
    longint tmin;
    longint tmax;
    longint theta;
    bit have_lo;
    bit have_hi;
    have_lo = 0;
    have_hi = 0;
    tmin = 0;
    tmax = 0;
    for (int f = 0; f < eff_faces(); f++) begin
      w = 80'(bnd[f]);
      slack = 80'(clamp32(w - (row_dot(f, 0) >>> 16)));
      rate = 80'(clamp32(row_dot(f, 1) >>> 16));
      if (rate == 0) continue;
      q = 80'(clamp32((slack * 80'sd65536) / rate));
      if (rate < 0) begin
        if (!have_lo || longint'(q) > tmin) tmin = longint'(q);
        have_lo = 1;
      end else begin
        if (!have_hi || longint'(q) < tmax) tmax = longint'(q);
        have_hi = 1;
      end
    end
    if (!have_lo || !have_hi) begin
      pending_results.push_back(mk_res(KIND_POINT, 0, 0, 1'b0, ERR_UNBOUNDED, 1'b1));
      return;
    end
    if (tmax < tmin) begin
      pending_results.push_back(mk_res(KIND_POINT, 0, 0, 1'b0, ERR_EMPTY, 1'b1));
      return;
    end
    theta = tmin + (((tmax - tmin) * longint'({48'd0, frac})) >>> 16);
    for (int j = 0; j < eff_dims(); j++) begin
      w = 80'(pt[j]);
      pt[j] = clamp32(w + 80'((theta * longint'(dir[j])) >>> 16));
    end
    if (fin) begin
      for (int j = 0; j < eff_dims(); j++) begin
        pending_results.push_back(mk_res(KIND_POINT, j, pt[j], 1'b0, ERR_NONE,
                                         j + 1 == eff_dims()));
      end
    end
  endfunction

  // update the shadow state and queue what an accepted request produces
  function automatic void predict_results(input phr_req_t r);
    logic signed [79:0] h;
    logic signed [79:0] acc;
    logic signed [79:0] w;
    bit ins;
    case (r.op)
      OP_WR_COEF:  coef[r.face_index][r.coord_index] = r.value;
      OP_WR_BOUND: bnd[r.face_index] = r.value;
      OP_WR_POINT: pt[r.coord_index] = r.value;
      OP_DIR: begin
        dir[r.coord_index] = r.value;
        if (int'(r.coord_index) + 1 == eff_dims()) chord_step(r.theta_fraction, r.final_step);
      end
      OP_MEMBER: begin
        ins = 1;
        for (int f = 0; f < eff_faces(); f++) begin
          acc = row_dot(f, 0);
          h = acc >>> 16;
          w = 80'(bnd[f]);
          if (!(h < w || (h == w && acc[15:0] == 0))) ins = 0;
        end
        pending_results.push_back(mk_res(KIND_MEMBER, 0, 0, ins, ERR_NONE, 1'b1));
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // check each result strobe against the oldest expectation
  always @(posedge clk) begin
    phr_res_t e;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_res));
      end else begin
        e = pending_results.pop_front();
        if (out_res.kind !== e.kind)
          report_mismatch($sformatf("kind %0b exp %0b", out_res.kind, e.kind));
        if (out_res.out_coord !== e.out_coord)
          report_mismatch($sformatf("out_coord %0d exp %0d", out_res.out_coord, e.out_coord));
        if (out_res.coord_value !== e.coord_value)
          report_mismatch($sformatf("coord_value %h exp %h", out_res.coord_value,
                                    e.coord_value));
        if (out_res.in_set !== e.in_set)
          report_mismatch($sformatf("in_set %0b exp %0b", out_res.in_set, e.in_set));
        if (out_res.error !== e.error)
          report_mismatch($sformatf("error %0d exp %0d", out_res.error, e.error));
        if (out_res.last_result !== e.last_result)
          report_mismatch($sformatf("last_result %0b exp %0b", out_res.last_result,
                                    e.last_result));
      end
    end
  end

  function automatic phr_req_t mk_req(logic [2:0] op, int face, int crd, int val,
                                      int frac = 0, bit fin = 1'b0);
    phr_req_t r;
    r.op = op;
    r.face_index = face[4:0];
    r.coord_index = crd[2:0];
    r.value = val;
    r.theta_fraction = frac[15:0];
    r.final_step = fin;
    return r;
  endfunction

  // send one request in bursts with random gaps; called just after a falling edge
  task automatic send(input phr_req_t r);
    if (burst_left == 0) begin
      if (bursty) repeat ($urandom_range(1, 9)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
      bursty = ($urandom_range(0, 3) != 0);
    end
    burst_left--;
    start = 1'b1;
    in_req = r;
    do @(posedge clk); while (busy);
    predict_results(r);
    @(negedge clk);
    start = 1'b0;
  endtask

  // hold off until every outstanding result has come, back on a falling edge
  task automatic drain();
    wait (pending_results.size() == 0);
    @(negedge clk);
  endtask

  // write a register once the block has drained and settled
  task automatic write_reg(input logic [1:0] idx, input int val);
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val[7:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FACE_COUNT) faces_raw = val & 'h3f;
    else dims_raw = val & 'hf;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int rnd_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // one full direction, the last component runs the step
  task automatic send_direction(input int span, input bit fin);
    int frac;
    frac = $urandom_range(0, 65535);
    for (int j = 0; j < eff_dims(); j++)
      send(mk_req(OP_DIR, $urandom, j, span == 0 ? $urandom : rnd_signed(span), frac, fin));
  endtask

  // box |x_j| <= half plus extra loose random faces, point inside
  task automatic load_box(input int half);
    for (int f = 0; f < eff_faces(); f++) begin
      for (int j = 0; j < eff_dims(); j++) begin
        if (f < 2 * eff_dims())
          send(mk_req(OP_WR_COEF, f, j, (j == f / 2) ? ((f % 2) ? -ONE : ONE) : 0));
        else
          send(mk_req(OP_WR_COEF, f, j, rnd_signed(2 * ONE)));
      end
      send(mk_req(OP_WR_BOUND, f, 0, f < 2 * eff_dims() ? half : 1000 * ONE));
    end
    for (int j = 0; j < eff_dims(); j++)
      send(mk_req(OP_WR_POINT, 0, j, rnd_signed(half / 2)));
  endtask

  // default one face, one coordinate: a single face bounds only one side
  task automatic test_reset_config();
    send(mk_req(OP_WR_COEF, 0, 0, ONE));
    send(mk_req(OP_WR_BOUND, 0, 0, ONE));
    send(mk_req(OP_WR_POINT, 0, 0, 0));
    send(mk_req(OP_MEMBER, 0, 0, 0));
    send(mk_req(OP_DIR, 0, 0, ONE, 'h1234, 1'b1));
  endtask

  task automatic test_directed_box();
    write_reg(CFG_DIM, 2);
    write_reg(CFG_FACE_COUNT, 4);
    load_box(ONE);
    send(mk_req(OP_WR_POINT, 0, 0, 0));
    send(mk_req(OP_WR_POINT, 0, 1, 0));
    // good step with point output
    send(mk_req(OP_DIR, 0, 0, ONE));
    send(mk_req(OP_DIR, 0, 1, ONE / 2, 'h8000, 1'b1));
    send(mk_req(OP_MEMBER, 0, 0, 0));
    // component that is not last: stored only
    send(mk_req(OP_DIR, 0, 0, 0, 'hffff, 1'b1));
    // zero direction: no face limits the chord
    send(mk_req(OP_DIR, 0, 1, 0, 'hffff, 1'b1));
    // contradictory bounds: empty chord
    send(mk_req(OP_WR_BOUND, 0, 0, -ONE));
    send(mk_req(OP_WR_BOUND, 1, 0, -ONE));
    send(mk_req(OP_DIR, 0, 0, ONE));
    send(mk_req(OP_DIR, 0, 1, 0, 0, 1'b1));
    send(mk_req(OP_MEMBER, 0, 0, 0));
    send(mk_req(OP_WR_BOUND, 0, 0, ONE));
    send(mk_req(OP_WR_BOUND, 1, 0, ONE));
    // extreme values, saturation on the move
    send(mk_req(OP_WR_POINT, 0, 0, 32'h7fff_ffff));
    send(mk_req(OP_DIR, 0, 0, 32'h7fff_ffff));
    send(mk_req(OP_DIR, 0, 1, 32'h8000_0000, 'hffff, 1'b1));
    send(mk_req(OP_WR_POINT, 0, 1, 32'h8000_0000));
    send(mk_req(OP_DIR, 0, 1, 32'h7fff_ffff, 0, 1'b1));
    // unused opcodes do nothing
    for (int op = OP_MEMBER + 1; op < 8; op++)
      send(mk_req(3'(op), $urandom, $urandom, $urandom, $urandom, 1'b1));
  endtask

  // random traffic on a box polytope for one setting of the registers
  task automatic test_random_phase(input int faces_val, input int dims_val, input int budget);
    int sent;
    int pick;
    write_reg(CFG_DIM, dims_val);
    write_reg(CFG_FACE_COUNT, faces_val);
    load_box(10 * ONE);
    // every direction component in use gets written before any random step
    send_direction(ONE, 1'b0);
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_direction(ONE, $urandom_range(0, 2) == 0);
        sent += eff_dims();
      end else if (pick < 75) begin
        send(mk_req(OP_MEMBER, $urandom, $urandom, $urandom));
        sent++;
      end else if (pick < 82) begin
        send(mk_req(OP_WR_POINT, 0, $urandom_range(0, eff_dims() - 1), rnd_signed(5 * ONE)));
        sent++;
      end else if (pick < 88) begin
        send_direction(0, 1'b1);
        sent += eff_dims();
      end else begin
        send(mk_req(3'($urandom), $urandom, $urandom, $urandom, $urandom, 1'($urandom)));
        sent++;
      end
      // hold off until every outstanding result has come
      if (pick == 50) drain();
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_config();
    test_directed_box();
    test_random_phase(4, 2, 30);
    test_random_phase(9, 3, 25);
    test_random_phase(63, 2, 15);
    test_random_phase(3, 15, 15);
    test_random_phase(0, 0, 15);
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* polytope_hit_and_run_step_top.f */
+incdir+sv
sv/phr_pkg.sv
sv/phr_divider.sv
sv/polytope_hit_and_run_step_top.sv
sv/phr_checker.sv
bench/polytope_hit_and_run_step_top_tb.sv
